FILE: hw/rtl/gdsa_pkg.sv
package gdsa_pkg;

  localparam int GLYPH_COLUMNS = 5;
  localparam int SRC_COLS      = 5;
  localparam int SRC_W         = 8;
  localparam int COL_W         = 2 * SRC_W;
  localparam int OUT_COLS      = 12;
  localparam int NUM_PAIRS     = (OUT_COLS - 2) / 2;
  localparam int WINDOWS       = 6;
  localparam int IDX_W         = 4;

  localparam logic [3:0] PAT_STEP_HI = 4'hC;
  localparam logic [3:0] PAT_STEP_LO = 4'h3;

  typedef logic [IDX_W-1:0] col_idx_t;
  localparam col_idx_t FIRST_COL_IDX = col_idx_t'(0);
  localparam col_idx_t LAST_COL_IDX  = col_idx_t'(OUT_COLS - 1);

  typedef logic [SRC_W-1:0] src_col_t;
  typedef logic [COL_W-1:0] col_t;
  typedef col_t [OUT_COLS-1:0] col_arr_t;

  typedef struct packed {
    col_t l;
    col_t r;
  } pair_fill_t;

  typedef pair_fill_t [NUM_PAIRS-1:0] pair_fill_arr_t;

  // Each source pixel becomes two vertically adjacent output pixels.
  function automatic col_t double_bits(input src_col_t v);
    col_t d;
    d = '0;
    for (int i = 0; i < SRC_W; i++) begin
      d[2*i]   = v[i];
      d[2*i+1] = v[i];
    end
    return d;
  endfunction

endpackage

FILE: hw/rtl/gdsa_ifs.sv
interface gdsa_in_if;
  import gdsa_pkg::*;
  logic     valid;
  logic     ready;
  src_col_t src_col0;
  src_col_t src_col1;
  src_col_t src_col2;
  src_col_t src_col3;
  src_col_t src_col4;
  modport source (output valid, src_col0, src_col1, src_col2, src_col3, src_col4,
                  input ready);
  modport sink (input valid, src_col0, src_col1, src_col2, src_col3, src_col4,
                output ready);
endinterface

interface gdsa_out_if;
  import gdsa_pkg::*;
  logic        valid;
  logic        ready;
  col_idx_t    out_col_index;
  logic [7:0]  upper_page_byte;
  logic [7:0]  lower_page_byte;
  logic        last_col;
  modport source (output valid, out_col_index, upper_page_byte, lower_page_byte, last_col,
                  input ready);
  modport sink (input valid, out_col_index, upper_page_byte, lower_page_byte, last_col,
                output ready);
endinterface

FILE: hw/rtl/glyph_double_scale_antialias.sv
// Doubles a 5x8 font glyph to twelve 16-pixel columns, with optional diagonal
// corner smoothing, and sends them one column per beat in column order,
// index 0 to 11, with last_col set on column 11. The next glyph is taken in
// the same cycle as the last column of the current one leaves the column
// buffer, so glyphs stream back to back while the output is not stalled.
// The first column passes through the column buffer and then the output
// register before it is offered. The smoothing lanes evaluate all column
// pairs in the accept cycle.
// cfg_wdata is latched into smooth_r whenever cfg_we is high; it resets
// to 1 and should only change while no glyph is in flight.
module glyph_double_scale_antialias (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  gdsa_in_if.sink           in_ch,
  gdsa_out_if.source        out_ch
);
  import gdsa_pkg::*;

  logic            smooth_r;
  logic            smooth_nxt;
  src_col_t [SRC_COLS-1:0] src;
  col_arr_t        raw;
  col_arr_t        merged;
  pair_fill_arr_t  fills;

  col_arr_t        glyph_r;
  logic            bv_r, bv_nxt;
  col_idx_t        col_r, col_nxt;
  logic            move;
  logic            in_acc;

  logic            out_valid_r, out_valid_nxt;
  col_idx_t        out_idx_r;
  col_t            out_col_r;
  logic            out_last_r;

  assign src[0] = in_ch.src_col0;
  assign src[1] = in_ch.src_col1;
  assign src[2] = in_ch.src_col2;
  assign src[3] = in_ch.src_col3;
  assign src[4] = in_ch.src_col4;

  // Columns 0 and 11, outside the doubled glyph, stay blank.
  always_comb begin
    raw = '0;
    for (int x = 0; x < GLYPH_COLUMNS; x++) begin
      raw[2*x+1] = double_bits(src[x]);
      raw[2*x+2] = double_bits(src[x]);
    end
  end

  for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_lane
    gdsa_pair_lane u_lane (
      .left_col  (raw[2*k+2]),
      .right_col (raw[2*k+3]),
      .smooth_en (smooth_r),
      .fill      (fills[k])
    );
  end

  gdsa_merge u_merge (
    .raw_cols (raw),
    .fills    (fills),
    .cols     (merged)
  );

  assign move         = bv_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !bv_r || (move && col_r == LAST_COL_IDX);
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign smooth_nxt = cfg_we ? cfg_wdata : smooth_r;

  always_comb begin
    bv_nxt  = bv_r;
    col_nxt = col_r;
    if (move) begin
      if (col_r == LAST_COL_IDX) begin
        bv_nxt  = 1'b0;
        col_nxt = FIRST_COL_IDX;
      end else begin
        col_nxt = col_r + col_idx_t'(1);
      end
    end
    if (in_acc) begin
      bv_nxt  = 1'b1;
      col_nxt = FIRST_COL_IDX;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r    <= 1'b1;
      bv_r        <= 1'b0;
      col_r       <= FIRST_COL_IDX;
      out_valid_r <= 1'b0;
    end else begin
      smooth_r    <= smooth_nxt;
      bv_r        <= bv_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      glyph_r <= merged;
    end
    if (move) begin
      out_idx_r  <= col_r;
      out_col_r  <= glyph_r[col_r];
      out_last_r <= (col_r == LAST_COL_IDX);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_col_index   = out_idx_r;
  assign out_ch.upper_page_byte = out_col_r[7:0];
  assign out_ch.lower_page_byte = out_col_r[15:8];
  assign out_ch.last_col        = out_last_r;

  a_idle_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !bv_r |-> col_r == FIRST_COL_IDX)
    else $error("column counter not at zero while buffer is free");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> bv_r && col_r == FIRST_COL_IDX)
    else $error("accepted glyph did not start at column zero");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_col |-> out_ch.out_col_index == LAST_COL_IDX)
    else $error("last_col raised on a column other than the last");

  a_blank_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.out_col_index == FIRST_COL_IDX ||
                     out_ch.out_col_index == LAST_COL_IDX)
    |-> out_ch.upper_page_byte == 8'h00 && out_ch.lower_page_byte == 8'h00)
    else $error("edge column is not blank");

endmodule

FILE: hw/rtl/gdsa_pair_lane.sv
module gdsa_pair_lane (
  input  gdsa_pkg::col_t       left_col,
  input  gdsa_pkg::col_t       right_col,
  input  logic                 smooth_en,
  output gdsa_pkg::pair_fill_t fill
);
  import gdsa_pkg::*;

  // The six windows overlap but only read the unsmoothed columns, so they
  // are independent of one another.
  always_comb begin
    logic [3:0] lw;
    logic [3:0] rw;
    fill = '0;
    for (int w = 0; w < WINDOWS; w++) begin
      lw = left_col[2*w +: 4];
      rw = right_col[2*w +: 4];
      if (smooth_en && lw == PAT_STEP_HI && rw == PAT_STEP_LO) begin
        fill.l[2*w+1] = 1'b1;
        fill.r[2*w+2] = 1'b1;
      end
      if (smooth_en && lw == PAT_STEP_LO && rw == PAT_STEP_HI) begin
        fill.l[2*w+2] = 1'b1;
        fill.r[2*w+1] = 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/gdsa_merge.sv
module gdsa_merge (
  input  gdsa_pkg::col_arr_t       raw_cols,
  input  gdsa_pkg::pair_fill_arr_t fills,
  output gdsa_pkg::col_arr_t       cols
);
  import gdsa_pkg::*;

  // Pair k covers output columns 2k+2 (left) and 2k+3 (right).
  always_comb begin
    cols = raw_cols;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      cols[2*k+2] = raw_cols[2*k+2] | fills[k].l;
      cols[2*k+3] = raw_cols[2*k+3] | fills[k].r;
    end
  end

endmodule
